[rtl/cau_pkg.sv]
// Shared types, widths and helper functions of the complex arithmetic unit.
// Depends on nothing; every other file of the unit uses it.
`timescale 1ns / 1ps

package cau_pkg;

  // Operand format: signed fixed point, DATA_WIDTH bits, FRAC_BITS fraction bits.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Full-width product, sum of two products, scaled divide numerator and overflow compare width.
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int SUM_W  = PROD_W + 1;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int CMP_W  = 3 * DATA_WIDTH;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // Saturated value with its saturation flag.
  typedef struct packed {
    word_t val;
    logic  sat;
  } sat_t;

  // One request as it travels down the divider pipeline. Requests that do
  // not divide carry their finished result in res_re, res_im and status.
  typedef struct packed {
    logic                  valid;
    logic                  is_div;
    logic                  div_zero;
    logic                  neg_re;
    logic                  neg_im;
    logic                  ovf_re;
    logic                  ovf_im;
    logic [PROD_W-1:0]     den;
    logic [PROD_W-1:0]     rem_re;
    logic [PROD_W-1:0]     rem_im;
    logic [DATA_WIDTH-1:0] nlo_re;
    logic [DATA_WIDTH-1:0] nlo_im;
    logic [DATA_WIDTH-1:0] q_re;
    logic [DATA_WIDTH-1:0] q_im;
    word_t                 res_re;
    word_t                 res_im;
    status_t               status;
  } div_stage_t;

  // Clamp a wide signed value to the signed DATA_WIDTH range.
  function automatic sat_t saturate(input logic [SUM_W-1:0] x);
    logic [SUM_W-DATA_WIDTH:0] hi;
    sat_t                      r;
    hi = x[SUM_W-1:DATA_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      r.val = x[DATA_WIDTH-1:0];
      r.sat = 1'b0;
    end else if (x[SUM_W-1]) begin
      r.val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      r.sat = 1'b1;
    end else begin
      r.val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/cau_if.sv]
// Valid/ready channel interfaces for the request and result sides.
// Depends on cau_pkg for the field widths.
`timescale 1ns / 1ps

interface cau_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im;
  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im;

  modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cau_pkg::DATA_WIDTH-1:0] r_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0] r_im;
  logic [1:0]                          status;

  modport source (output valid, r_re, r_im, status, input ready);
  modport sink   (input valid, r_re, r_im, status, output ready);
endinterface

[rtl/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: front end, divider, output stage.
// Depends on cau_pkg, cau_if, cau_front and cau_divider.
//
//   Channel   Direction  Handshake          Contents
//   in_ch     sink       valid/ready        mode, a_re, a_im, b_re, b_im
//   out_ch    source     valid/ready        r_re, r_im, status
//
// Every request passes through one product stage, one sum stage, one setup
// stage, one divider stage per quotient bit and the output register. All
// modes take the same path, so results leave in order. One request can
// enter each cycle while no result waits untaken. A stall on out_ch freezes
// the whole pipeline; in_ch.ready is low only while a result waits untaken.
// Synchronous reset clears the valid bits only.
`timescale 1ns / 1ps

module complex_arithmetic_unit (
  input  logic     clk,
  input  logic     rst_n,
  cau_in_if.sink   in_ch,
  cau_out_if.source out_ch
);
  import cau_pkg::*;

  logic       en;
  div_stage_t prep, last;

  logic       out_valid_r;
  word_t      out_re_r, out_im_r, out_re_nxt, out_im_nxt;
  status_t    out_status_r, out_status_nxt;

  // The pipeline moves whenever the output register is free or drained.
  assign en = !out_valid_r || out_ch.ready;

  cau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_ch  (in_ch),
    .prep_o (prep)
  );

  cau_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .stage_i (prep),
    .stage_o (last)
  );

  // Clamp a quotient magnitude with its sign to the signed result range.
  function automatic sat_t quot_sat(input word_t q, input logic neg, input logic ovf);
    sat_t r;
    if (neg) begin
      if (ovf || (q[DATA_WIDTH-1] && |q[DATA_WIDTH-2:0])) begin
        r.val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        r.sat = 1'b1;
      end else begin
        r.val = -q;
        r.sat = 1'b0;
      end
    end else begin
      if (ovf || q[DATA_WIDTH-1]) begin
        r.val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        r.sat = 1'b1;
      end else begin
        r.val = q;
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

  // Final result selection.
  always_comb begin
    sat_t d_re, d_im;
    d_re = quot_sat(last.q_re, last.neg_re, last.ovf_re);
    d_im = quot_sat(last.q_im, last.neg_im, last.ovf_im);
    if (!last.is_div) begin
      out_re_nxt     = last.res_re;
      out_im_nxt     = last.res_im;
      out_status_nxt = last.status;
    end else if (last.div_zero) begin
      out_re_nxt     = '0;
      out_im_nxt     = '0;
      out_status_nxt = ST_DIV_ZERO;
    end else begin
      out_re_nxt     = d_re.val;
      out_im_nxt     = d_im.val;
      out_status_nxt = (d_re.sat || d_im.sat) ? ST_SAT : ST_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r     <= out_re_nxt;
      out_im_r     <= out_im_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.r_re   = out_re_r;
  assign out_ch.r_im   = out_im_r;
  assign out_ch.status = out_status_r;

  // A divide by zero always delivers a zero result.
  a_div_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_DIV_ZERO) |-> (out_re_r == '0 && out_im_r == '0))
    else $error("divide by zero with nonzero result");

  // A saturated result has at least one part at a range limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_SAT) |->
      (out_re_r == {1'b1, {(DATA_WIDTH-1){1'b0}}} || out_re_r == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
       out_im_r == {1'b1, {(DATA_WIDTH-1){1'b0}}} || out_im_r == {1'b0, {(DATA_WIDTH-1){1'b1}}}))
    else $error("saturation status without a clamped part");

  // A valid request leaving the divider lands in the output register.
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && last.valid) |=> out_valid_r)
    else $error("request lost between divider and output");

  // While stalled, the divider's last stage holds its request.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && last.valid) |=> (last.valid && $stable(last.q_re) && $stable(last.q_im)))
    else $error("divider moved during a stall");

endmodule

[rtl/cau_front.sv]
// Front end: product stage, sum stage and divide setup stage.
// Depends on cau_pkg and cau_in_if.
`timescale 1ns / 1ps

module cau_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  cau_in_if.sink              in_ch,
  output cau_pkg::div_stage_t prep_o
);
  import cau_pkg::*;

  // Stage 1 registers: products and add/subtract sums.
  logic                       v1_r;
  mode_t                      mode1_r;
  logic signed [PROD_W-1:0]   ac1_r, bd1_r, ad1_r, bc1_r, cc1_r, dd1_r;
  logic signed [DATA_WIDTH:0] as_re1_r, as_im1_r;
  logic signed [DATA_WIDTH:0] as_re_nxt, as_im_nxt;

  // Stage 2 registers: combined numerators and divisor.
  logic                       v2_r;
  mode_t                      mode2_r;
  logic signed [SUM_W-1:0]    num_re2_r, num_im2_r;
  logic [PROD_W-1:0]          den2_r;
  logic signed [DATA_WIDTH:0] as_re2_r, as_im2_r;
  logic signed [SUM_W-1:0]    num_re_nxt, num_im_nxt;

  // Stage 3 register.
  div_stage_t                 prep_r, prep_nxt;

  assign in_ch.ready = en;

  // Add or subtract each part with one guard bit.
  always_comb begin
    if (mode_t'(in_ch.mode) == MODE_SUB) begin
      as_re_nxt = {in_ch.a_re[DATA_WIDTH-1], in_ch.a_re} - {in_ch.b_re[DATA_WIDTH-1], in_ch.b_re};
      as_im_nxt = {in_ch.a_im[DATA_WIDTH-1], in_ch.a_im} - {in_ch.b_im[DATA_WIDTH-1], in_ch.b_im};
    end else begin
      as_re_nxt = {in_ch.a_re[DATA_WIDTH-1], in_ch.a_re} + {in_ch.b_re[DATA_WIDTH-1], in_ch.b_re};
      as_im_nxt = {in_ch.a_im[DATA_WIDTH-1], in_ch.a_im} + {in_ch.b_im[DATA_WIDTH-1], in_ch.b_im};
    end
  end

  // Stage 1: the six full-width products and the add/subtract sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r  <= mode_t'(in_ch.mode);
      ac1_r    <= PROD_W'(in_ch.a_re) * PROD_W'(in_ch.b_re);
      bd1_r    <= PROD_W'(in_ch.a_im) * PROD_W'(in_ch.b_im);
      ad1_r    <= PROD_W'(in_ch.a_re) * PROD_W'(in_ch.b_im);
      bc1_r    <= PROD_W'(in_ch.a_im) * PROD_W'(in_ch.b_re);
      cc1_r    <= PROD_W'(in_ch.b_re) * PROD_W'(in_ch.b_re);
      dd1_r    <= PROD_W'(in_ch.b_im) * PROD_W'(in_ch.b_im);
      as_re1_r <= as_re_nxt;
      as_im1_r <= as_im_nxt;
    end
  end

  // Multiply and divide combine the products with opposite signs.
  always_comb begin
    if (mode1_r == MODE_DIV) begin
      num_re_nxt = SUM_W'(ac1_r) + SUM_W'(bd1_r);
      num_im_nxt = SUM_W'(bc1_r) - SUM_W'(ad1_r);
    end else begin
      num_re_nxt = SUM_W'(ac1_r) - SUM_W'(bd1_r);
      num_im_nxt = SUM_W'(ad1_r) + SUM_W'(bc1_r);
    end
  end

  // Stage 2: numerators and the divisor c^2 + d^2.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r   <= mode1_r;
      num_re2_r <= num_re_nxt;
      num_im2_r <= num_im_nxt;
      den2_r    <= PROD_W'(cc1_r) + PROD_W'(dd1_r);
      as_re2_r  <= as_re1_r;
      as_im2_r  <= as_im1_r;
    end
  end

  // Stage 3: finish add, subtract and multiply; set up the division.
  always_comb begin
    logic [SUM_W-1:0] bias_re, bias_im, sc_re, sc_im;
    logic [PROD_W-1:0] mag_re, mag_im;
    logic [NUM_W-1:0]  nf_re, nf_im;
    logic [CMP_W-1:0]  den_top;
    sat_t              s_re, s_im;

    bias_re = num_re2_r[SUM_W-1] ? (SUM_W'(1) << FRAC_BITS) - SUM_W'(1) : '0;
    bias_im = num_im2_r[SUM_W-1] ? (SUM_W'(1) << FRAC_BITS) - SUM_W'(1) : '0;
    sc_re   = SUM_W'($signed(num_re2_r + $signed(bias_re)) >>> FRAC_BITS);
    sc_im   = SUM_W'($signed(num_im2_r + $signed(bias_im)) >>> FRAC_BITS);

    if (mode2_r == MODE_MUL) begin
      s_re = saturate(sc_re);
      s_im = saturate(sc_im);
    end else begin
      s_re = saturate(SUM_W'(as_re2_r));
      s_im = saturate(SUM_W'(as_im2_r));
    end

    // Magnitudes of the divide numerators, scaled up by the fraction bits.
    mag_re  = num_re2_r[SUM_W-1] ? PROD_W'(-num_re2_r) : num_re2_r[PROD_W-1:0];
    mag_im  = num_im2_r[SUM_W-1] ? PROD_W'(-num_im2_r) : num_im2_r[PROD_W-1:0];
    nf_re   = NUM_W'(mag_re) << FRAC_BITS;
    nf_im   = NUM_W'(mag_im) << FRAC_BITS;
    den_top = CMP_W'(den2_r) << DATA_WIDTH;

    prep_nxt.valid    = v2_r;
    prep_nxt.is_div   = (mode2_r == MODE_DIV);
    prep_nxt.div_zero = (den2_r == '0);
    prep_nxt.neg_re   = num_re2_r[SUM_W-1];
    prep_nxt.neg_im   = num_im2_r[SUM_W-1];
    // A quotient of 2^DATA_WIDTH or more saturates whatever its sign.
    prep_nxt.ovf_re   = (CMP_W'(nf_re) >= den_top);
    prep_nxt.ovf_im   = (CMP_W'(nf_im) >= den_top);
    prep_nxt.den      = den2_r;
    prep_nxt.rem_re   = PROD_W'(nf_re >> DATA_WIDTH);
    prep_nxt.rem_im   = PROD_W'(nf_im >> DATA_WIDTH);
    prep_nxt.nlo_re   = nf_re[DATA_WIDTH-1:0];
    prep_nxt.nlo_im   = nf_im[DATA_WIDTH-1:0];
    prep_nxt.q_re     = '0;
    prep_nxt.q_im     = '0;
    prep_nxt.res_re   = s_re.val;
    prep_nxt.res_im   = s_im.val;
    prep_nxt.status   = (s_re.sat || s_im.sat) ? ST_SAT : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else if (en) begin
      prep_r.valid <= prep_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r.is_div   <= prep_nxt.is_div;
      prep_r.div_zero <= prep_nxt.div_zero;
      prep_r.neg_re   <= prep_nxt.neg_re;
      prep_r.neg_im   <= prep_nxt.neg_im;
      prep_r.ovf_re   <= prep_nxt.ovf_re;
      prep_r.ovf_im   <= prep_nxt.ovf_im;
      prep_r.den      <= prep_nxt.den;
      prep_r.rem_re   <= prep_nxt.rem_re;
      prep_r.rem_im   <= prep_nxt.rem_im;
      prep_r.nlo_re   <= prep_nxt.nlo_re;
      prep_r.nlo_im   <= prep_nxt.nlo_im;
      prep_r.q_re     <= prep_nxt.q_re;
      prep_r.q_im     <= prep_nxt.q_im;
      prep_r.res_re   <= prep_nxt.res_re;
      prep_r.res_im   <= prep_nxt.res_im;
      prep_r.status   <= prep_nxt.status;
    end
  end

  assign prep_o = prep_r;

endmodule

[rtl/cau_divider.sv]
// Pipelined restoring divider: one quotient bit per stage for both parts.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cau_pkg::div_stage_t stage_i,
  output cau_pkg::div_stage_t stage_o
);
  import cau_pkg::*;

  div_stage_t stage_r [DATA_WIDTH];

  // One shift, compare and subtract step on both remainders.
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t       r;
    logic [PROD_W:0]  sh_re, sh_im, df_re, df_im;
    r     = s;
    sh_re = {s.rem_re, s.nlo_re[DATA_WIDTH-1]};
    sh_im = {s.rem_im, s.nlo_im[DATA_WIDTH-1]};
    df_re = sh_re - {1'b0, s.den};
    df_im = sh_im - {1'b0, s.den};
    r.rem_re = df_re[PROD_W] ? sh_re[PROD_W-1:0] : df_re[PROD_W-1:0];
    r.rem_im = df_im[PROD_W] ? sh_im[PROD_W-1:0] : df_im[PROD_W-1:0];
    r.q_re   = {s.q_re[DATA_WIDTH-2:0], ~df_re[PROD_W]};
    r.q_im   = {s.q_im[DATA_WIDTH-2:0], ~df_im[PROD_W]};
    r.nlo_re = {s.nlo_re[DATA_WIDTH-2:0], 1'b0};
    r.nlo_im = {s.nlo_im[DATA_WIDTH-2:0], 1'b0};
    return r;
  endfunction

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
    div_stage_t prev, step_nxt;

    if (i == 0) begin : g_first
      assign prev = stage_i;
    end else begin : g_next
      assign prev = stage_r[i-1];
    end

    assign step_nxt = div_step(prev);

    // Only the valid bit is reset; the payload follows it.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[i].valid <= 1'b0;
      end else if (en) begin
        stage_r[i].valid <= step_nxt.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[i].is_div   <= step_nxt.is_div;
        stage_r[i].div_zero <= step_nxt.div_zero;
        stage_r[i].neg_re   <= step_nxt.neg_re;
        stage_r[i].neg_im   <= step_nxt.neg_im;
        stage_r[i].ovf_re   <= step_nxt.ovf_re;
        stage_r[i].ovf_im   <= step_nxt.ovf_im;
        stage_r[i].den      <= step_nxt.den;
        stage_r[i].rem_re   <= step_nxt.rem_re;
        stage_r[i].rem_im   <= step_nxt.rem_im;
        stage_r[i].nlo_re   <= step_nxt.nlo_re;
        stage_r[i].nlo_im   <= step_nxt.nlo_im;
        stage_r[i].q_re     <= step_nxt.q_re;
        stage_r[i].q_im     <= step_nxt.q_im;
        stage_r[i].res_re   <= step_nxt.res_re;
        stage_r[i].res_im   <= step_nxt.res_im;
        stage_r[i].status   <= step_nxt.status;
      end
    end
  end

  assign stage_o = stage_r[DATA_WIDTH-1];

endmodule
